[sv/meb_pkg.sv]
// shared types and constants for the mandelbrot escape-time unit
// no dependencies; imported by every module of the block
package meb_pkg;

   // fixed-point format of c and z
   localparam int FRAC_BITS   = 28;
   localparam int IN_WIDTH    = 31;
   localparam int Z_WIDTH     = 32;
   localparam int PROD_WIDTH  = 64;
   localparam int COUNT_WIDTH = 16;

   // escape radius squared, 4.0 with 2*FRAC_BITS fraction bits
   localparam logic [PROD_WIDTH-1:0] ESCAPE_THRESHOLD =
      PROD_WIDTH'(4) << ((2 * FRAC_BITS) % PROD_WIDTH);

   // iteration limit after reset
   localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(1000);

   typedef logic signed [IN_WIDTH-1:0] coord_type;
   typedef logic signed [Z_WIDTH-1:0]  z_type;
   typedef logic [PROD_WIDTH-1:0]      prod_type;
   typedef logic [COUNT_WIDTH-1:0]     count_type;

   // products handed from the square cell to the step cell
   typedef struct packed {
      logic     valid;
      prod_type re_sq;
      prod_type im_sq;
      prod_type cross_term;
   } square_word_type;

   // completion report from the step cell
   typedef struct packed {
      logic      done;
      logic      escaped;
      count_type count;
   } step_status_type;

endpackage

[sv/meb_square_cell.sv]
// square cell: registers zr^2, zi^2 and 2*zr*zi for the current z
// depends on meb_pkg
module meb_square_cell
   import meb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            z_valid,
   input  z_type           z_re,
   input  z_type           z_im,
   output square_word_type square_word
);

   logic signed [PROD_WIDTH-1:0] re_sq_full;
   logic signed [PROD_WIDTH-1:0] im_sq_full;
   logic signed [PROD_WIDTH-1:0] re_im_full;

   logic     valid_ff;
   prod_type re_sq_ff;
   prod_type im_sq_ff;
   prod_type cross_ff;

   // full-width products
   assign re_sq_full = z_re * z_re;
   assign im_sq_full = z_im * z_im;
   assign re_im_full = z_re * z_im;

   // product registers, token travels on to the step cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= z_valid;
      end
      re_sq_ff <= prod_type'(re_sq_full);
      im_sq_ff <= prod_type'(im_sq_full);
      cross_ff <= {re_im_full[PROD_WIDTH-2:0], 1'b0};
   end

   assign square_word.valid      = valid_ff;
   assign square_word.re_sq      = re_sq_ff;
   assign square_word.im_sq      = im_sq_ff;
   assign square_word.cross_term = cross_ff;

endmodule

[sv/meb_step_cell.sv]
// step cell: escape test, count and next z from the squared terms
// depends on meb_pkg; feeds meb_square_cell in a two-cell ring
module meb_step_cell
   import meb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  coord_type       c_real,
   input  coord_type       c_imag,
   input  count_type       limit,
   input  square_word_type square_word,
   output logic            z_valid,
   output z_type           z_re,
   output z_type           z_im,
   output step_status_type status
);

   prod_type                     mag_sq;
   logic                         escape_hit;
   logic signed [PROD_WIDTH-1:0] re_diff;
   logic signed [PROD_WIDTH-1:0] re_scaled;
   logic signed [PROD_WIDTH-1:0] im_scaled;
   z_type                        z_re_in;
   z_type                        z_im_in;
   count_type                    count_in;

   logic      z_valid_ff;
   z_type     z_re_ff;
   z_type     z_im_ff;
   z_type     c_re_ff;
   z_type     c_im_ff;
   count_type count_ff;
   logic      done_ff;
   logic      escaped_ff;

   // escape test on |z|^2
   assign mag_sq     = square_word.re_sq + square_word.im_sq;
   assign escape_hit = mag_sq > ESCAPE_THRESHOLD;

   // rescale with arithmetic shift, then add c
   assign re_diff   = signed'(square_word.re_sq - square_word.im_sq);
   assign re_scaled = re_diff >>> FRAC_BITS;
   assign im_scaled = signed'(square_word.cross_term) >>> FRAC_BITS;
   assign z_re_in   = signed'(re_scaled[Z_WIDTH-1:0]) + c_re_ff;
   assign z_im_in   = signed'(im_scaled[Z_WIDTH-1:0]) + c_im_ff;
   assign count_in  = count_ff + COUNT_WIDTH'(1);

   // z, c and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         z_valid_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         z_valid_ff <= 1'b0;
         done_ff    <= 1'b0;
         if (start) begin
            z_valid_ff <= 1'b1;
         end else if (square_word.valid) begin
            if (escape_hit) begin
               done_ff <= 1'b1;
            end else if (count_in == limit) begin
               done_ff <= 1'b1;
            end else begin
               z_valid_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         c_re_ff    <= Z_WIDTH'(c_real);
         c_im_ff    <= Z_WIDTH'(c_imag);
         z_re_ff    <= Z_WIDTH'(c_real);
         z_im_ff    <= Z_WIDTH'(c_imag);
         count_ff   <= '0;
         escaped_ff <= 1'b0;
      end else if (square_word.valid) begin
         if (escape_hit) begin
            escaped_ff <= 1'b1;
         end else begin
            z_re_ff  <= z_re_in;
            z_im_ff  <= z_im_in;
            count_ff <= count_in;
         end
      end
   end

   assign z_valid        = z_valid_ff;
   assign z_re           = z_re_ff;
   assign z_im           = z_im_ff;
   assign status.done    = done_ff;
   assign status.escaped = escaped_ff;
   assign status.count   = count_ff;

endmodule

[sv/mandelbrot_escape_time_unit.sv]
// mandelbrot escape-time unit: one point in flight, one iteration per trip around the ring
// a point accepted while the limit is 0 is answered with count 0, not escaped, without entering the ring
// the square cell and step cell form a two-register loop, which sets the rate
// a new point can be taken in the same cycle that the previous result appears in the output word
// reset: synchronous, active high; clears control and sets the limit to 1000
module mandelbrot_escape_time_unit
   import meb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  coord_type req_c_real,
   input  coord_type req_c_imag,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output count_type rsp_iteration_count,
   output logic      rsp_escaped,
   input  logic      csr_write_en,
   input  count_type csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   state_type       state_ff;
   state_type       state_in;
   count_type       limit_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   count_type       rsp_count_ff;
   count_type       rsp_count_in;
   logic            rsp_escaped_ff;
   logic            rsp_escaped_in;
   count_type       hold_count_ff;
   count_type       hold_count_in;
   logic            hold_escaped_ff;
   logic            hold_escaped_in;

   logic            accept;
   logic            limit_zero;
   logic            start;
   logic            out_free;
   logic            z_valid;
   z_type           z_re;
   z_type           z_im;
   square_word_type square_word;
   step_status_type status;

   assign req_ready  = state_ff == ST_IDLE;
   assign accept     = req_valid && req_ready;
   assign limit_zero = limit_ff == '0;
   assign start      = accept && !limit_zero;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // two-cell ring
   meb_square_cell u_square (
      .clock       (clock),
      .reset       (reset),
      .z_valid     (z_valid),
      .z_re        (z_re),
      .z_im        (z_im),
      .square_word (square_word)
   );

   meb_step_cell u_step (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .c_real      (req_c_real),
      .c_imag      (req_c_imag),
      .limit       (limit_ff),
      .square_word (square_word),
      .z_valid     (z_valid),
      .z_re        (z_re),
      .z_im        (z_im),
      .status      (status)
   );

   // next state and output word
   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_count_in    = rsp_count_ff;
      rsp_escaped_in  = rsp_escaped_ff;
      hold_count_in   = hold_count_ff;
      hold_escaped_in = hold_escaped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!limit_zero) begin
                  state_in = ST_RUN;
               end else if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_count_in   = '0;
                  rsp_escaped_in = 1'b0;
               end else begin
                  hold_count_in   = '0;
                  hold_escaped_in = 1'b0;
                  state_in        = ST_HOLD;
               end
            end
         end
         ST_RUN: begin
            if (status.done) begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_count_in   = status.count;
                  rsp_escaped_in = status.escaped;
                  state_in       = ST_IDLE;
               end else begin
                  hold_count_in   = status.count;
                  hold_escaped_in = status.escaped;
                  state_in        = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_count_in   = hold_count_ff;
               rsp_escaped_in = hold_escaped_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, limit register, hold registers and output word registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
      end
      rsp_count_ff    <= rsp_count_in;
      rsp_escaped_ff  <= rsp_escaped_in;
      hold_count_ff   <= hold_count_in;
      hold_escaped_ff <= hold_escaped_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_escaped         = rsp_escaped_ff;

   // completion only while a point is running
   a_done_in_run : assert property (@(posedge clock) disable iff (reset)
      status.done |-> state_ff == ST_RUN)
      else $error("step cell reported completion outside run");

   // a single token circulates in the ring
   a_one_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0({z_valid, square_word.valid, status.done}))
      else $error("more than one token in the ring");

   // a result held back only while the output word is occupied
   a_hold_needs_busy_out : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_valid_ff)
      else $error("hold state with a free output word");

   // a point that did not escape ran exactly the limit
   a_limit_count : assert property (@(posedge clock) disable iff (reset)
      status.done && !status.escaped |-> status.count == limit_ff)
      else $error("non-escaped count differs from the limit");

   // an escape comes before the limit
   a_escape_count : assert property (@(posedge clock) disable iff (reset)
      status.done && status.escaped |-> status.count < limit_ff)
      else $error("escape count not below the limit");

endmodule
